// ----- hw/rtl/nmz_pkg.sv -----
// Package with the shared types, widths and constants of the normal map z reconstruction core.
`timescale 1ns / 1ps

package nmz_pkg;

   localparam int FRAC_BITS = 16;

   // Component width: signed Q.F, magnitude up to 1.0 and z down to about -0.42.
   localparam int CW      = FRAC_BITS + 2;
   localparam int SQW     = 2 * FRAC_BITS + 1;
   localparam int RADW    = 2 * FRAC_BITS + 2;
   localparam int ROOTW   = FRAC_BITS + 1;
   localparam int REMW    = FRAC_BITS + 3;
   localparam int BASEW   = FRAC_BITS + 1;
   localparam int NUMW    = FRAC_BITS + 10;
   localparam int DIV_STEPS = 8;

   // Division by 127 uses 2^7 = 1 mod 127, so 2^F = 127 * Q127 + 2^R127.
   localparam int R127 = FRAC_BITS % 7;
   localparam int Q127 = ((2 ** FRAC_BITS) - (2 ** R127)) / 127;

   // Cycles from an accepted item to its result strobe.
   localparam int LATENCY = 2 * FRAC_BITS + 18;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic signed [7:0] red_in;
      logic signed [7:0] green_in;
      logic              last_pixel;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
      logic       last_out;
   } rsp_type;

   // Data that rides alongside a radicand through the square root pipeline.
   typedef struct packed {
      logic signed [CW-1:0] r;
      logic signed [CW-1:0] g;
      logic signed [CW-1:0] z;
      logic [RADW-1:0]      n;
      logic                 last;
   } side_type;

   // First half of the snorm8 scaling.
   typedef struct packed {
      logic [BASEW-1:0] base;
      logic [12:0]      t;
      logic [6:0]       est;
      logic             pos;
      logic             neg;
   } scl_type;

endpackage

// ----- hw/rtl/nmz_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, carrying side data along.
`timescale 1ns / 1ps

module nmz_isqrt
   import nmz_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [RADW-1:0]  in_rad,
   input  side_type         in_side,
   output logic             out_valid,
   output logic [ROOTW-1:0] out_root,
   output side_type         out_side
);

   localparam int STEPS = ROOTW;

   logic             valid_ff [STEPS];
   logic [REMW-1:0]  rem_ff   [STEPS];
   logic [ROOTW-1:0] root_ff  [STEPS];
   logic [RADW-1:0]  rad_ff   [STEPS];
   side_type         side_ff  [STEPS];

   logic             valid_in [STEPS];
   logic [REMW-1:0]  rem_in   [STEPS];
   logic [ROOTW-1:0] root_in  [STEPS];
   logic [RADW-1:0]  rad_in   [STEPS];
   side_type         side_in  [STEPS];

   always_comb begin
      logic [REMW-1:0]   rem_p;
      logic [ROOTW-1:0]  root_p;
      logic [RADW-1:0]   rad_p;
      logic [REMW+1:0]   cur;
      logic [REMW+1:0]   trial;
      for (int k = 0; k < STEPS; k++) begin
         if (k == 0) begin
            valid_in[k] = in_valid;
            side_in[k]  = in_side;
            rem_p       = '0;
            root_p      = '0;
            rad_p       = in_rad;
         end else begin
            valid_in[k] = valid_ff[k-1];
            side_in[k]  = side_ff[k-1];
            rem_p       = rem_ff[k-1];
            root_p      = root_ff[k-1];
            rad_p       = rad_ff[k-1];
         end
         // Bring down the next two radicand bits and try root*4+1.
         cur   = {rem_p, rad_p[RADW-1 -: 2]};
         trial = (REMW+2)'({root_p, 2'b01});
         if (cur >= trial) begin
            rem_in[k]  = REMW'(cur - trial);
            root_in[k] = {root_p[ROOTW-2:0], 1'b1};
         end else begin
            rem_in[k]  = REMW'(cur);
            root_in[k] = {root_p[ROOTW-2:0], 1'b0};
         end
         rad_in[k] = rad_p << 2;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STEPS; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_in[k];
         end
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         rad_ff[k]  <= rad_in[k];
         side_ff[k] <= side_in[k];
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

// ----- hw/rtl/normal_map_z_reconstruct_core.sv -----
// Top level of the normal map z reconstruction core: scaling, two square roots and division.
`timescale 1ns / 1ps
//
// The core turns a two-channel signed normal map texel into an RGBA unorm8 pixel.
// Input: an item (red, green, last flag) is taken on a rising edge with start high
// and busy low. Busy is high only while reset is asserted, so outside reset an item
// may enter on every cycle.
// Output: each result appears on rsp_data for exactly one cycle with rsp_valid high.
// The receiver cannot hold results off, and the core never needs it to.
// Each item passes through the input register, the scaling, the squares and their sum,
// the first square root pipeline, z squared, the length sum, the second square root
// pipeline (one stage per root bit in each), the divider operand register and the
// eight-stage restoring divider that forms the output bytes. Throughput is one item per cycle.
// Reset is synchronous: it clears every stage valid bit, so items in flight are
// dropped and no result is shown until a new item has passed through.
// Alpha is always 255 and the last flag is carried through unchanged.
//
module normal_map_z_reconstruct_core
   import nmz_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   function automatic scl_type scl_first(logic signed [7:0] v);
      scl_type     s;
      logic [7:0]  mag;
      logic [20:0] tm;
      mag   = v[7] ? 8'(-v) : 8'(v);
      s.pos = !v[7] && (v != 8'sd0);
      s.neg = v[7];
      s.t   = 13'((13'(mag) << R127) + 13'd63);
      tm    = 21'(s.t) * 21'd129;
      s.est = 7'(tm >> 14);
      if (s.pos) begin
         s.base = BASEW'(32'(mag) * 32'(Q127));
      end else begin
         s.base = BASEW'(BASEW'(mag) << (FRAC_BITS - 7));
      end
      return s;
   endfunction

   function automatic logic signed [CW-1:0] scl_second(scl_type s);
      logic [13:0]      rem;
      logic [BASEW-1:0] q;
      rem = 14'(s.t) - 14'(14'(s.est) * 14'd127);
      q   = s.base;
      if (s.pos) begin
         q = BASEW'(q + BASEW'(s.est) + BASEW'(rem >= 14'd127));
      end
      return s.neg ? -$signed(CW'(q)) : $signed(CW'(q));
   endfunction

   // Input register.
   logic    in_v_ff;
   req_type in_d_ff;

   // Scaling, two stages.
   logic    s1_v_ff;
   scl_type s1_r_ff, s1_g_ff;
   logic    s1_last_ff;
   logic    s2_v_ff;
   logic signed [CW-1:0] s2_r_ff, s2_g_ff;
   logic    s2_last_ff;

   // Squares and their sum.
   logic    sq_v_ff;
   logic [SQW-1:0] sq_r2_ff, sq_g2_ff;
   logic signed [CW-1:0] sq_r_ff, sq_g_ff;
   logic    sq_last_ff;
   logic    n1_v_ff;
   side_type n1_side_ff;

   // First square root gives s, then z and z squared.
   logic             q1_v;
   logic [ROOTW-1:0] q1_root;
   side_type         q1_side;
   logic             z2_v_ff;
   logic [SQW-1:0]   z2_ff;
   side_type         z2_side_ff;
   logic             n2_v_ff;
   side_type         n2_side_ff;

   // Second square root gives the length.
   logic             q2_v;
   logic [ROOTW-1:0] q2_root;
   side_type         q2_side;

   // Divider operands and stages.
   logic            pv_ff;
   logic [NUMW-1:0] pnum_ff [3];
   logic [NUMW-1:0] pden_ff;
   logic            plast_ff;

   logic            dv_ff    [DIV_STEPS];
   logic [NUMW-1:0] drem_ff  [DIV_STEPS][3];
   logic [7:0]      dq_ff    [DIV_STEPS][3];
   logic [NUMW-1:0] dden_ff  [DIV_STEPS];
   logic            dlast_ff [DIV_STEPS];

   logic signed [CW-1:0] z_in;
   logic signed [2*CW-1:0] r2_full_in, g2_full_in, z2_full_in;
   side_type n1_side_in, z2_side_in, n2_side_in;
   logic [NUMW-1:0] pnum_in [3];
   logic [NUMW-1:0] pden_in;

   logic            dv_in    [DIV_STEPS];
   logic [NUMW-1:0] drem_in  [DIV_STEPS][3];
   logic [7:0]      dq_in    [DIV_STEPS][3];
   logic [NUMW-1:0] dden_in  [DIV_STEPS];
   logic            dlast_in [DIV_STEPS];

   assign busy = reset;

   // Front end arithmetic.
   always_comb begin
      r2_full_in = $signed((2*CW)'(s2_r_ff)) * $signed((2*CW)'(s2_r_ff));
      g2_full_in = $signed((2*CW)'(s2_g_ff)) * $signed((2*CW)'(s2_g_ff));

      n1_side_in      = '0;
      n1_side_in.r    = sq_r_ff;
      n1_side_in.g    = sq_g_ff;
      n1_side_in.n    = RADW'(sq_r2_ff) + RADW'(sq_g2_ff);
      n1_side_in.last = sq_last_ff;

      z_in       = $signed(CW'(2 ** FRAC_BITS)) - $signed(CW'(q1_root));
      z2_full_in = $signed((2*CW)'(z_in)) * $signed((2*CW)'(z_in));
      z2_side_in   = q1_side;
      z2_side_in.z = z_in;

      n2_side_in   = z2_side_ff;
      n2_side_in.n = z2_side_ff.n + RADW'(z2_ff);
   end

   // Divider operands: numerator 255 * (c + len), denominator 2 * len.
   always_comb begin
      logic signed [CW:0]   sum;
      logic signed [CW-1:0] c;
      logic [NUMW-1:0]      su;
      for (int l = 0; l < 3; l++) begin
         case (l)
            0:       c = q2_side.r;
            1:       c = q2_side.g;
            default: c = q2_side.z;
         endcase
         sum = $signed((CW+1)'(c)) + $signed((CW+1)'(q2_root));
         su  = NUMW'(unsigned'(sum));
         if (sum <= 0) begin
            pnum_in[l] = '0;
         end else begin
            pnum_in[l] = NUMW'((su << 8) - su);
         end
      end
      if (q2_root == '0) begin
         pden_in = NUMW'(1);
      end else begin
         pden_in = NUMW'({q2_root, 1'b0});
      end
   end

   // Restoring division, one quotient bit per stage, three lanes.
   always_comb begin
      logic [NUMW-1:0] rem_p;
      logic [7:0]      q_p;
      logic [NUMW-1:0] den_p;
      logic [NUMW-1:0] dsh;
      for (int i = 0; i < DIV_STEPS; i++) begin
         if (i == 0) begin
            dv_in[i]    = pv_ff;
            dden_in[i]  = pden_ff;
            dlast_in[i] = plast_ff;
         end else begin
            dv_in[i]    = dv_ff[i-1];
            dden_in[i]  = dden_ff[i-1];
            dlast_in[i] = dlast_ff[i-1];
         end
         den_p = dden_in[i];
         dsh   = den_p << (DIV_STEPS - 1 - i);
         for (int l = 0; l < 3; l++) begin
            if (i == 0) begin
               rem_p = pnum_ff[l];
               q_p   = '0;
            end else begin
               rem_p = drem_ff[i-1][l];
               q_p   = dq_ff[i-1][l];
            end
            if (rem_p >= dsh) begin
               drem_in[i][l] = rem_p - dsh;
               dq_in[i][l]   = {q_p[6:0], 1'b1};
            end else begin
               drem_in[i][l] = rem_p;
               dq_in[i][l]   = {q_p[6:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         sq_v_ff <= 1'b0;
         n1_v_ff <= 1'b0;
         z2_v_ff <= 1'b0;
         n2_v_ff <= 1'b0;
         pv_ff   <= 1'b0;
      end else begin
         in_v_ff <= start && !busy;
         s1_v_ff <= in_v_ff;
         s2_v_ff <= s1_v_ff;
         sq_v_ff <= s2_v_ff;
         n1_v_ff <= sq_v_ff;
         z2_v_ff <= q1_v;
         n2_v_ff <= z2_v_ff;
         pv_ff   <= q2_v;
      end
      in_d_ff    <= req_data;
      s1_r_ff    <= scl_first(in_d_ff.red_in);
      s1_g_ff    <= scl_first(in_d_ff.green_in);
      s1_last_ff <= in_d_ff.last_pixel;
      s2_r_ff    <= scl_second(s1_r_ff);
      s2_g_ff    <= scl_second(s1_g_ff);
      s2_last_ff <= s1_last_ff;
      sq_r2_ff   <= SQW'(unsigned'(r2_full_in));
      sq_g2_ff   <= SQW'(unsigned'(g2_full_in));
      sq_r_ff    <= s2_r_ff;
      sq_g_ff    <= s2_g_ff;
      sq_last_ff <= s2_last_ff;
      n1_side_ff <= n1_side_in;
      z2_ff      <= SQW'(unsigned'(z2_full_in));
      z2_side_ff <= z2_side_in;
      n2_side_ff <= n2_side_in;
      pnum_ff    <= pnum_in;
      pden_ff    <= pden_in;
      plast_ff   <= q2_side.last;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIV_STEPS; i++) begin
         if (reset) begin
            dv_ff[i] <= 1'b0;
         end else begin
            dv_ff[i] <= dv_in[i];
         end
         dden_ff[i]  <= dden_in[i];
         dlast_ff[i] <= dlast_in[i];
         drem_ff[i]  <= drem_in[i];
         dq_ff[i]    <= dq_in[i];
      end
   end

   nmz_isqrt u_sqrt_s (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n1_v_ff),
      .in_rad    (n1_side_ff.n),
      .in_side   (n1_side_ff),
      .out_valid (q1_v),
      .out_root  (q1_root),
      .out_side  (q1_side)
   );

   nmz_isqrt u_sqrt_len (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n2_v_ff),
      .in_rad    (n2_side_ff.n),
      .in_side   (n2_side_ff),
      .out_valid (q2_v),
      .out_root  (q2_root),
      .out_side  (q2_side)
   );

   assign rsp_valid          = dv_ff[DIV_STEPS-1];
   assign rsp_data.red_out   = dq_ff[DIV_STEPS-1][0];
   assign rsp_data.green_out = dq_ff[DIV_STEPS-1][1];
   assign rsp_data.blue_out  = dq_ff[DIV_STEPS-1][2];
   assign rsp_data.alpha_out = ALPHA_OPAQUE;
   assign rsp_data.last_out  = dlast_ff[DIV_STEPS-1];

   // Every accepted item comes out as a result strobe.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted item did not produce a result on time");

   // No result strobe appears without a matching accepted item.
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##LATENCY !rsp_valid)
      else $error("result strobe without a matching item");

   // The last flag follows its item through the whole pipeline.
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY (rsp_data.last_out == $past(req_data.last_pixel, LATENCY)))
      else $error("last flag lost its item");

   // A zero texel maps to the straight-up normal.
   a_zero_texel: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.red_in == 8'sd0 && req_data.green_in == 8'sd0)
      |-> ##LATENCY (rsp_data.red_out == 8'd127 && rsp_data.green_out == 8'd127
                     && rsp_data.blue_out == 8'd255))
      else $error("zero texel gave the wrong normal");

endmodule

// ----- tb/normal_map_z_reconstruct_core_tb.sv -----
// Testbench for the normal map z reconstruction core: random and directed pixels.
`timescale 1ns / 1ps

module normal_map_z_reconstruct_core_tb
   import nmz_pkg::*;
();

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   req_type pixel_queue[$];
   rsp_type expected_pixels[$];
   int      error_count;
   int      sent_count;
   int      burst_left;
   int      gap_left;
   bit      hold_sender;

   normal_map_z_reconstruct_core u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint snorm_to_fixed(logic signed [7:0] v);
      longint mag;
      longint den;
      longint q;
      mag = (v < 0) ? -longint'(v) : longint'(v);
      den = (v > 0) ? 127 : 128;
      q = ((mag << FRAC_BITS) + den / 2) / den;
      return (v < 0) ? -q : q;
   endfunction

   function automatic longint floor_sqrt(longint n);
      longint root;
      longint bitpos;
      root = 0;
      bitpos = longint'(1) << 62;
      while (bitpos > n) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (n >= root + bitpos) begin
            n = n - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return root;
   endfunction

   function automatic logic [7:0] component_byte(longint c, longint len);
      longint sum;
      longint q;
      sum = c + len;
      if (len == 0 || sum <= 0) return 8'd0;
      q = (255 * sum) / (2 * len);
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function automatic rsp_type reconstruct_pixel(req_type px);
      rsp_type res;
      longint  r;
      longint  g;
      longint  z;
      longint  s;
      longint  len;
      r = snorm_to_fixed(px.red_in);
      g = snorm_to_fixed(px.green_in);
      s = floor_sqrt(r * r + g * g);
      z = (longint'(1) << FRAC_BITS) - s;
      len = floor_sqrt(r * r + g * g + z * z);
      res.red_out = component_byte(r, len);
      res.green_out = component_byte(g, len);
      res.blue_out = component_byte(z, len);
      res.alpha_out = ALPHA_OPAQUE;
      res.last_out = px.last_pixel;
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic push_pixel(int red, int green, bit last);
      req_type px;
      px.red_in = red[7:0];
      px.green_in = green[7:0];
      px.last_pixel = last;
      pixel_queue.push_back(px);
   endtask

   // Driver: bursts of items separated by random gaps, changes on the falling edge.
   always @(negedge clock) begin
      if (reset || hold_sender) begin
         start <= 1'b0;
      end else if (start && busy) begin
         start <= 1'b1;
      end else begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pixel_queue.size() == 0) begin
            start <= 1'b0;
         end else begin
            req_data <= pixel_queue.pop_front();
            start <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(40, 0);
               gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            end
         end
      end
   end

   // Monitor: expectations are formed when an item is accepted and compared in order.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && start && !busy) begin
         expected_pixels.push_back(reconstruct_pixel(req_data));
         sent_count++;
      end
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected result strobe", 1, 0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_data.red_out !== want.red_out)
               report_mismatch("red", rsp_data.red_out, want.red_out);
            if (rsp_data.green_out !== want.green_out)
               report_mismatch("green", rsp_data.green_out, want.green_out);
            if (rsp_data.blue_out !== want.blue_out)
               report_mismatch("blue", rsp_data.blue_out, want.blue_out);
            if (rsp_data.alpha_out !== want.alpha_out)
               report_mismatch("alpha", rsp_data.alpha_out, want.alpha_out);
            if (rsp_data.last_out !== want.last_out)
               report_mismatch("last", rsp_data.last_out, want.last_out);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("** normal_map_z_reconstruct_core: FAILED **");
      $finish;
   end

   initial begin
      int idx;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      error_count = 0;
      sent_count = 0;
      burst_left = 0;
      gap_left = 0;
      hold_sender = 1'b0;

      // Extremes, the zero texel, and the sign boundaries of both scalings.
      push_pixel(0, 0, 0);
      push_pixel(127, 0, 0);
      push_pixel(-128, 0, 1);
      push_pixel(0, 127, 0);
      push_pixel(0, -128, 0);
      push_pixel(127, 127, 1);
      push_pixel(-128, -128, 0);
      push_pixel(127, -128, 0);
      push_pixel(-128, 127, 1);
      push_pixel(1, -1, 0);
      push_pixel(-1, 1, 0);
      push_pixel(64, -64, 1);
      push_pixel(90, 90, 0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (idx = 0; idx < 900; idx++)
         push_pixel($urandom_range(255, 0), $urandom_range(255, 0), $urandom_range(1, 0));

      wait (pixel_queue.size() == 0 && !start);
      // Let the pipeline drain completely before the second half.
      @(negedge clock);
      hold_sender = 1'b1;
      wait (expected_pixels.size() == 0);
      @(negedge clock);
      hold_sender = 1'b0;

      for (idx = 0; idx < 940; idx++)
         push_pixel($urandom_range(255, 0), $urandom_range(255, 0), $urandom_range(1, 0));

      wait (pixel_queue.size() == 0);
      @(negedge clock);
      wait (!start);
      wait (expected_pixels.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("** normal_map_z_reconstruct_core: PASSED **");
      end else begin
         $display("** normal_map_z_reconstruct_core: FAILED **");
      end
      $finish;
   end

endmodule

// ----- normal_map_z_reconstruct_core.f -----
hw/rtl/nmz_pkg.sv
hw/rtl/nmz_isqrt.sv
hw/rtl/normal_map_z_reconstruct_core.sv
tb/normal_map_z_reconstruct_core_tb.sv
